FILE: sv/gbf_pkg.sv
package gbf_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int MAX_RESULTS      = 63;

    localparam int END_W  = 7;
    localparam int MODE_W = 2;
    localparam int EDGE_W = 9;
    localparam int CNT_W  = 6;
    localparam int VC_W   = 7;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
        logic [END_W-1:0]  end_a;
        logic [END_W-1:0]  end_b;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic [EDGE_W-1:0] bridge_edge;
        logic [CNT_W-1:0]  bridge_count;
        logic              last;
        logic              load_dropped;
    } t_result;

endpackage

FILE: sv/graph_bridge_finder_unit.sv
// Bridge finder for an undirected multigraph held in on-chip memory.
// Requests enter on start/i_mode/i_end_a/i_end_b and are taken when start
// is high and busy is low. A load stores one edge per cycle, so loads can
// follow each other back to back; a clear does not raise busy either.
// Neither produces a result.
// A run raises busy from the next cycle while the depth-first walk runs:
// a wipe of the vertex and mark memories, then a walk over all edges for
// each visited vertex, plus a scan of all edges for each tree edge that
// needs a parallel-edge check, then a pass over the marks to count the
// bridges and a pass to report them.
// Results come out in ascending edge order, one o_valid cycle each,
// last marking the end; with no bridges a single zero result is given.
// The receiver cannot stall; results are not held.
// Reset empties the graph, clears the dropped flag and sets vertex_count
// to 64 (or MAX_VERTICES if smaller). The user must write vertex_count
// through the APB port only while the block is idle; it is not enforced.
module graph_bridge_finder_unit #(
    parameter int MAX_VERTICES = gbf_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = gbf_pkg::MAX_EDGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gbf_pkg::MODE_W-1:0]  i_mode,
    input  logic [gbf_pkg::END_W-1:0]   i_end_a,
    input  logic [gbf_pkg::END_W-1:0]   i_end_b,
    output logic                        o_valid,
    output logic [gbf_pkg::EDGE_W-1:0]  o_bridge_edge,
    output logic [gbf_pkg::CNT_W-1:0]   o_bridge_count,
    output logic                        o_last,
    output logic                        o_load_dropped,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CW = (MAX_VERTICES + 1 > 128) ? $clog2(MAX_VERTICES + 1) + 1 : 8;
    localparam logic [gbf_pkg::VC_W-1:0] VC_RST =
        gbf_pkg::VC_W'((MAX_VERTICES < 64) ? MAX_VERTICES : 64);

    logic [gbf_pkg::VC_W-1:0] r_vc;
    logic [gbf_pkg::VC_W-1:0] wr_val;
    logic                     wr_en;
    gbf_pkg::t_cmd            cmd;
    gbf_pkg::t_result         res;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'd0 || 1'b1);
    assign wr_val = pwdata[gbf_pkg::VC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= VC_RST;
        end else if (wr_en) begin
            if (wr_val == '0) begin
                r_vc <= gbf_pkg::VC_W'(1);
            end else if (CW'(wr_val) > CW'(MAX_VERTICES)) begin
                r_vc <= gbf_pkg::VC_W'(MAX_VERTICES);
            end else begin
                r_vc <= wr_val;
            end
        end
    end

    assign prdata = 32'(r_vc);

    assign cmd = '{valid: start && !busy, mode: i_mode, end_a: i_end_a, end_b: i_end_b};

    gbf_core #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES   (MAX_EDGES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_vertex_count(r_vc),
        .o_busy        (busy),
        .o_result      (res)
    );

    assign o_valid        = res.valid;
    assign o_bridge_edge  = res.bridge_edge;
    assign o_bridge_count = res.bridge_count;
    assign o_last         = res.last;
    assign o_load_dropped = res.load_dropped;

endmodule

FILE: sv/gbf_core.sv
module gbf_core #(
    parameter int MAX_VERTICES = gbf_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = gbf_pkg::MAX_EDGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gbf_pkg::t_cmd             i_cmd,
    input  logic [gbf_pkg::VC_W-1:0]  i_vertex_count,
    output logic                      o_busy,
    output gbf_pkg::t_result          o_result
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VW1 = $clog2(MAX_VERTICES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW1 = $clog2(MAX_EDGES + 1);
    localparam int AW  = (VW1 + 1 > gbf_pkg::END_W + 1) ? VW1 + 1 : gbf_pkg::END_W + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_ROOT_RD = 4'd2;
    localparam logic [3:0] S_ROOT_EV = 4'd3;
    localparam logic [3:0] S_EDGE_RD = 4'd4;
    localparam logic [3:0] S_EDGE_EV = 4'd5;
    localparam logic [3:0] S_VTX_EV  = 4'd6;
    localparam logic [3:0] S_POP_EV  = 4'd7;
    localparam logic [3:0] S_MULT_RD = 4'd8;
    localparam logic [3:0] S_MULT_EV = 4'd9;
    localparam logic [3:0] S_CNT_RD  = 4'd10;
    localparam logic [3:0] S_CNT_EV  = 4'd11;
    localparam logic [3:0] S_EMIT_RD = 4'd12;
    localparam logic [3:0] S_EMIT_EV = 4'd13;

    typedef struct packed {
        logic [VW-1:0] a;
        logic [VW-1:0] b;
    } t_edge;

    typedef struct packed {
        logic          visited;
        logic [VW-1:0] depth;
    } t_vtx;

    typedef struct packed {
        logic [VW-1:0]  v;
        logic [VW-1:0]  par;
        logic           has_par;
        logic [EW1-1:0] nxt;
        logic [EW-1:0]  via;
        logic [VW-1:0]  low;
    } t_frame;

    t_edge  edge_mem  [MAX_EDGES];
    t_vtx   vtx_mem   [MAX_VERTICES];
    t_frame stack_mem [MAX_VERTICES];
    logic   mark_mem  [MAX_EDGES];

    logic [3:0]       r_state, n_state;
    logic [EW1-1:0]   r_total, n_total;
    logic             r_dropped, n_dropped;
    logic [VW1-1:0]   r_root, n_root;
    logic [EW1-1:0]   r_si, n_si;
    logic [VW-1:0]    r_lvl, n_lvl;
    t_frame           r_top, n_top;
    logic [EW-1:0]    r_cur_e, n_cur_e;
    logic [VW-1:0]    r_u, n_u;
    logic [VW-1:0]    r_cv, n_cv;
    logic [VW-1:0]    r_clow, n_clow;
    logic [EW-1:0]    r_cvia, n_cvia;
    logic [1:0]       r_mc, n_mc;
    logic [gbf_pkg::CNT_W-1:0] r_tot, n_tot;
    logic [gbf_pkg::CNT_W-1:0] r_k, n_k;
    gbf_pkg::t_result r_res, n_res;

    logic          e_we, v_we, s_we, m_we, m_wd;
    logic [EW-1:0] e_waddr, e_raddr, m_waddr, m_raddr;
    logic [VW-1:0] v_waddr, v_raddr, s_waddr, s_raddr;
    t_edge         e_wd, e_rd;
    t_vtx          v_wd, v_rd;
    t_frame        s_wd, s_rd;
    logic          m_rd;

    logic [AW-1:0] vc_x, a_x, b_x, ea_x, eb_x;
    logic          e_live;
    logic [VW-1:0] u_sel;

    always_ff @(posedge i_clk) begin
        if (e_we) edge_mem[e_waddr] <= e_wd;
        e_rd <= edge_mem[e_raddr];
        if (v_we) vtx_mem[v_waddr] <= v_wd;
        v_rd <= vtx_mem[v_raddr];
        if (s_we) stack_mem[s_waddr] <= s_wd;
        s_rd <= stack_mem[s_raddr];
        if (m_we) mark_mem[m_waddr] <= m_wd;
        m_rd <= mark_mem[m_raddr];
    end

    assign vc_x  = AW'(i_vertex_count);
    assign a_x   = AW'(i_cmd.end_a);
    assign b_x   = AW'(i_cmd.end_b);
    assign ea_x  = AW'(e_rd.a);
    assign eb_x  = AW'(e_rd.b);
    assign e_live = (ea_x < vc_x) && (eb_x < vc_x);

    always_comb begin
        n_state = r_state;  n_total = r_total;  n_dropped = r_dropped;
        n_root = r_root;    n_si = r_si;        n_lvl = r_lvl;
        n_top = r_top;      n_cur_e = r_cur_e;  n_u = r_u;
        n_cv = r_cv;        n_clow = r_clow;    n_cvia = r_cvia;
        n_mc = r_mc;        n_tot = r_tot;      n_k = r_k;
        n_res = r_res;
        n_res.valid = 1'b0;
        n_res.load_dropped = r_dropped;
        e_we = 1'b0;  e_waddr = r_total[EW-1:0];
        e_wd = '{a: VW'(a_x - AW'(1)), b: VW'(b_x - AW'(1))};
        e_raddr = r_top.nxt[EW-1:0];
        v_we = 1'b0;  v_waddr = r_root[VW-1:0];  v_wd = '0;
        v_raddr = r_root[VW-1:0];
        s_we = 1'b0;  s_waddr = r_lvl;  s_wd = r_top;
        s_raddr = r_lvl - VW'(1);
        m_we = 1'b0;  m_waddr = r_si[EW-1:0];  m_wd = 1'b0;
        m_raddr = r_si[EW-1:0];
        u_sel = (e_rd.a == r_top.v) ? e_rd.b : e_rd.a;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.mode)
                        gbf_pkg::MODE_LOAD: begin
                            if (a_x == '0 || a_x > vc_x || b_x == '0 || b_x > vc_x ||
                                r_total >= EW1'(MAX_EDGES)) begin
                                n_dropped = 1'b1;
                            end else begin
                                e_we = 1'b1;
                                n_total = r_total + EW1'(1);
                            end
                        end
                        gbf_pkg::MODE_RUN: begin
                            n_si = '0;
                            n_root = '0;
                            n_state = S_CLR;
                        end
                        gbf_pkg::MODE_CLEAR: begin
                            n_total = '0;
                            n_dropped = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                // visited and marks wiped in parallel sweeps
                if (r_si < r_total) begin
                    m_we = 1'b1;
                    n_si = r_si + EW1'(1);
                end
                if (AW'(r_root) < vc_x) begin
                    v_we = 1'b1;
                    n_root = r_root + VW1'(1);
                end
                if (r_si >= r_total && AW'(r_root) >= vc_x) begin
                    n_root = '0;
                    n_state = S_ROOT_RD;
                end
            end
            S_ROOT_RD: begin
                if (AW'(r_root) >= vc_x) begin
                    n_si = '0;
                    n_tot = '0;
                    n_state = S_CNT_RD;
                end else begin
                    n_state = S_ROOT_EV;
                end
            end
            S_ROOT_EV: begin
                if (v_rd.visited) begin
                    n_root = r_root + VW1'(1);
                    n_state = S_ROOT_RD;
                end else begin
                    v_we = 1'b1;
                    v_wd = '{visited: 1'b1, depth: '0};
                    n_top = '{v: r_root[VW-1:0], par: '0, has_par: 1'b0,
                              nxt: '0, via: '0, low: '0};
                    n_lvl = '0;
                    n_state = S_EDGE_RD;
                end
            end
            S_EDGE_RD: begin
                if (r_top.nxt >= r_total) begin
                    if (r_lvl == '0) begin
                        n_root = r_root + VW1'(1);
                        n_state = S_ROOT_RD;
                    end else begin
                        n_cv = r_top.v;
                        n_clow = r_top.low;
                        n_cvia = r_top.via;
                        n_lvl = r_lvl - VW'(1);
                        n_state = S_POP_EV;
                    end
                end else begin
                    n_cur_e = r_top.nxt[EW-1:0];
                    n_top.nxt = r_top.nxt + EW1'(1);
                    n_state = S_EDGE_EV;
                end
            end
            S_EDGE_EV: begin
                v_raddr = u_sel;
                n_state = S_EDGE_RD;
                if (e_live && (e_rd.a == r_top.v || e_rd.b == r_top.v) &&
                    !(r_top.has_par && u_sel == r_top.par)) begin
                    n_u = u_sel;
                    n_state = S_VTX_EV;
                end
            end
            S_VTX_EV: begin
                n_state = S_EDGE_RD;
                if (v_rd.visited) begin
                    if (v_rd.depth < r_top.low) n_top.low = v_rd.depth;
                end else begin
                    // push the current frame, child becomes top
                    v_we = 1'b1;
                    v_waddr = r_u;
                    v_wd = '{visited: 1'b1, depth: r_lvl + VW'(1)};
                    s_we = 1'b1;
                    n_lvl = r_lvl + VW'(1);
                    n_top = '{v: r_u, par: r_top.v, has_par: 1'b1, nxt: '0,
                              via: r_cur_e, low: r_lvl + VW'(1)};
                end
            end
            S_POP_EV: begin
                n_top = s_rd;
                if (r_clow < s_rd.low) n_top.low = r_clow;
                n_state = S_EDGE_RD;
                if (r_clow > r_lvl) begin
                    n_si = '0;
                    n_mc = '0;
                    n_state = S_MULT_RD;
                end
            end
            S_MULT_RD: begin
                if (r_si >= r_total) begin
                    if (r_mc == 2'd1) begin
                        m_we = 1'b1;
                        m_waddr = r_cvia;
                        m_wd = 1'b1;
                    end
                    n_state = S_EDGE_RD;
                end else begin
                    e_raddr = r_si[EW-1:0];
                    n_si = r_si + EW1'(1);
                    n_state = S_MULT_EV;
                end
            end
            S_MULT_EV: begin
                if (e_live && r_mc != 2'd2 &&
                    ((e_rd.a == r_top.v && e_rd.b == r_cv) ||
                     (e_rd.a == r_cv && e_rd.b == r_top.v))) begin
                    n_mc = r_mc + 2'd1;
                end
                n_state = S_MULT_RD;
            end
            S_CNT_RD: begin
                if (r_si >= r_total) begin
                    n_si = '0;
                    n_k = '0;
                    if (r_tot == '0) begin
                        n_res = '{valid: 1'b1, bridge_edge: '0, bridge_count: '0,
                                  last: 1'b1, load_dropped: r_dropped};
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    n_si = r_si + EW1'(1);
                    n_state = S_CNT_EV;
                end
            end
            S_CNT_EV: begin
                if (m_rd && r_tot != gbf_pkg::CNT_W'(gbf_pkg::MAX_RESULTS)) begin
                    n_tot = r_tot + gbf_pkg::CNT_W'(1);
                end
                n_state = S_CNT_RD;
            end
            S_EMIT_RD: begin
                if (r_k == r_tot || r_si >= r_total) begin
                    n_state = S_IDLE;
                end else begin
                    n_cur_e = r_si[EW-1:0];
                    n_si = r_si + EW1'(1);
                    n_state = S_EMIT_EV;
                end
            end
            S_EMIT_EV: begin
                if (m_rd) begin
                    n_res.valid = 1'b1;
                    n_res.bridge_edge = gbf_pkg::EDGE_W'(EW1'(r_cur_e) + EW1'(1));
                    n_res.bridge_count = r_tot;
                    n_res.last = (r_k + gbf_pkg::CNT_W'(1)) == r_tot;
                    n_k = r_k + gbf_pkg::CNT_W'(1);
                end
                n_state = S_EMIT_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_dropped <= 1'b0;
            r_res <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_dropped <= n_dropped;
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= n_root;  r_si <= n_si;      r_lvl <= n_lvl;
        r_top <= n_top;    r_cur_e <= n_cur_e; r_u <= n_u;
        r_cv <= n_cv;      r_clow <= n_clow;  r_cvia <= n_cvia;
        r_mc <= n_mc;      r_tot <= n_tot;    r_k <= n_k;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_result = r_res;

endmodule

FILE: verif/graph_bridge_finder_unit_tb.sv
`timescale 1ns / 1ps

module graph_bridge_finder_unit_tb;

    localparam int NV = gbf_pkg::MAX_VERTICES_DEF;
    localparam int NE = gbf_pkg::MAX_EDGES_DEF;
    localparam logic [gbf_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam int STALL_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN} t_kind;

    typedef struct {
        t_kind                      kind;
        logic [gbf_pkg::MODE_W-1:0] mode;
        logic [gbf_pkg::END_W-1:0]  a;
        logic [gbf_pkg::END_W-1:0]  b;
        logic [31:0]                cfg;
    } t_item;

    typedef struct {
        logic [gbf_pkg::EDGE_W-1:0] bridge_edge;
        logic [gbf_pkg::CNT_W-1:0]  bridge_count;
        logic                       last;
        logic                       dropped;
    } t_bridge;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [gbf_pkg::MODE_W-1:0] i_mode;
    logic [gbf_pkg::END_W-1:0]  i_end_a;
    logic [gbf_pkg::END_W-1:0]  i_end_b;
    logic                       o_valid;
    logic [gbf_pkg::EDGE_W-1:0] o_bridge_edge;
    logic [gbf_pkg::CNT_W-1:0]  o_bridge_count;
    logic                       o_last;
    logic                       o_load_dropped;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [1:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    graph_bridge_finder_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_end_a        (i_end_a),
        .i_end_b        (i_end_b),
        .o_valid        (o_valid),
        .o_bridge_edge  (o_bridge_edge),
        .o_bridge_count (o_bridge_count),
        .o_last         (o_last),
        .o_load_dropped (o_load_dropped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // graph mirror
    int      vc_now;
    int      edge_a_q [NE];
    int      edge_b_q [NE];
    int      edge_cnt;
    bit      drop_seen;
    t_bridge bridges_due[$];

    t_item   pending[$];
    int      mismatches;
    int      quiet;
    int      stall;
    int      gap_left;
    int      apb_phase;
    bit      rst_done;
    bit      acc;
    bit      burst;

    function automatic bit is_live(int i);
        return edge_a_q[i] < vc_now && edge_b_q[i] < vc_now;
    endfunction

    function automatic int multiplicity(int x, int y);
        int n;
        n = 0;
        for (int i = 0; i < edge_cnt; i++)
            if (is_live(i) && ((edge_a_q[i] == x && edge_b_q[i] == y) ||
                               (edge_a_q[i] == y && edge_b_q[i] == x)))
                n++;
        return n;
    endfunction

    // DFS with low-link, then queue bridges in ascending edge order
    function automatic void predict_bridges();
        bit      seen [NV];
        int      dep  [NV];
        int      lowv [NV];
        bit      mark [NE];
        int      s_v  [NV];
        int      s_p  [NV];
        int      s_n  [NV];
        int      s_e  [NV];
        int      sp, v, i, u, pv, total, k;
        t_bridge r;
        for (int j = 0; j < NV; j++) seen[j] = 0;
        for (int j = 0; j < NE; j++) mark[j] = 0;
        for (int root = 0; root < vc_now; root++) begin
            if (seen[root]) continue;
            seen[root] = 1;
            dep[root] = 0;
            lowv[root] = 0;
            s_v[0] = root;
            s_p[0] = -1;
            s_n[0] = 0;
            s_e[0] = 0;
            sp = 1;
            while (sp > 0) begin
                v = s_v[sp-1];
                i = s_n[sp-1];
                if (i >= edge_cnt) begin
                    sp--;
                    if (sp > 0) begin
                        pv = s_v[sp-1];
                        if (lowv[v] < lowv[pv]) lowv[pv] = lowv[v];
                        if (lowv[v] > dep[pv] && multiplicity(pv, v) == 1)
                            mark[s_e[sp]] = 1;
                    end
                    continue;
                end
                s_n[sp-1] = i + 1;
                if (!is_live(i)) continue;
                if (edge_a_q[i] == v) u = edge_b_q[i];
                else if (edge_b_q[i] == v) u = edge_a_q[i];
                else continue;
                if (u == s_p[sp-1]) continue;
                if (seen[u]) begin
                    if (dep[u] < lowv[v]) lowv[v] = dep[u];
                end else if (sp < NV) begin
                    seen[u] = 1;
                    dep[u] = dep[v] + 1;
                    lowv[u] = dep[u];
                    s_v[sp] = u;
                    s_p[sp] = v;
                    s_n[sp] = 0;
                    s_e[sp] = i;
                    sp++;
                end
            end
        end
        total = 0;
        for (int j = 0; j < edge_cnt; j++) if (mark[j]) total++;
        if (total > gbf_pkg::MAX_RESULTS) total = gbf_pkg::MAX_RESULTS;
        r.dropped = drop_seen;
        if (total == 0) begin
            r.bridge_edge = '0;
            r.bridge_count = '0;
            r.last = 1'b1;
            bridges_due.insert(bridges_due.size(), r);
            return;
        end
        k = 0;
        for (int j = 0; j < edge_cnt && k < total; j++) begin
            if (!mark[j]) continue;
            r.bridge_edge = gbf_pkg::EDGE_W'(j + 1);
            r.bridge_count = gbf_pkg::CNT_W'(total);
            r.last = (k + 1 == total);
            bridges_due.insert(bridges_due.size(), r);
            k++;
        end
    endfunction

    function automatic void apply_request(logic [gbf_pkg::MODE_W-1:0] m, int a, int b);
        if (m == gbf_pkg::MODE_LOAD) begin
            if (a < 1 || a > vc_now || b < 1 || b > vc_now || edge_cnt >= NE)
                drop_seen = 1;
            else begin
                edge_a_q[edge_cnt] = a - 1;
                edge_b_q[edge_cnt] = b - 1;
                edge_cnt++;
            end
        end else if (m == gbf_pkg::MODE_CLEAR) begin
            edge_cnt = 0;
            drop_seen = 0;
        end else if (m == gbf_pkg::MODE_RUN) begin
            predict_bridges();
        end
    endfunction

    // monitor and checker
    always @(posedge i_clk) begin
        t_bridge e;
        int v;
        bit took;
        took = 1'b0;
        if (rst_done) begin
            stall++;
            if (bridges_due.size() == 0 && !busy) quiet++;
            else quiet = 0;
            if (start && !busy) begin
                apply_request(i_mode, int'(i_end_a), int'(i_end_b));
                took = 1'b1;
                stall = 0;
                quiet = 0;
            end
            if (psel && penable && pwrite && pready && paddr == REG_VERTEX_COUNT) begin
                v = pwdata & 32'h7f;
                if (v < 1) v = 1;
                if (v > NV) v = NV;
                vc_now = v;
            end
            if (o_valid) begin
                stall = 0;
                quiet = 0;
                if (bridges_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result edge=%0d count=%0d last=%0b drop=%0b",
                                 o_bridge_edge, o_bridge_count, o_last, o_load_dropped);
                end else begin
                    e = bridges_due.pop_front();
                    if (e.bridge_edge !== o_bridge_edge || e.bridge_count !== o_bridge_count ||
                        e.last !== o_last || e.dropped !== o_load_dropped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("bad result exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                     e.bridge_edge, e.bridge_count, e.last, e.dropped,
                                     o_bridge_edge, o_bridge_count, o_last, o_load_dropped);
                    end
                end
            end
            if (stall >= STALL_LIMIT) begin
                $display("graph_bridge_finder_unit: mismatch");
                $finish;
            end
        end
        acc <= took;
    end

    // request driver
    always @(negedge i_clk) begin
        logic  nxt_start;
        t_item h;
        bit    idle_ok;
        nxt_start = start;
        if (rst_done) begin
            if (acc) begin
                nxt_start = 1'b0;
                if ($urandom_range(0, 19) == 0) burst = !burst;
                gap_left = burst ? 0 : $urandom_range(0, 14);
            end
            idle_ok = bridges_due.size() == 0 && !busy && quiet >= SETTLE_CYCLES && !start;
            if (apb_phase == 1) begin
                penable <= 1'b1;
                apb_phase = 2;
            end else if (apb_phase == 2) begin
                psel <= 1'b0;
                penable <= 1'b0;
                pwrite <= 1'b0;
                void'(pending.pop_front());
                apb_phase = 0;
            end else if (!nxt_start && pending.size() > 0) begin
                h = pending[0];
                if (gap_left > 0) gap_left--;
                else if (h.kind == K_REQ) begin
                    i_mode <= h.mode;
                    i_end_a <= h.a;
                    i_end_b <= h.b;
                    nxt_start = 1'b1;
                    void'(pending.pop_front());
                end else if (idle_ok && h.kind == K_DRAIN) begin
                    void'(pending.pop_front());
                end else if (idle_ok && h.kind == K_CFG) begin
                    psel <= 1'b1;
                    pwrite <= 1'b1;
                    paddr <= REG_VERTEX_COUNT;
                    pwdata <= h.cfg;
                    apb_phase = 1;
                end
            end
        end
        start <= nxt_start;
    end

    int reqs;
    int gen_vc;

    task automatic push_req(logic [gbf_pkg::MODE_W-1:0] m, int a = 1, int b = 1);
        t_item t;
        t.kind = K_REQ;
        t.mode = m;
        t.a = gbf_pkg::END_W'(a);
        t.b = gbf_pkg::END_W'(b);
        t.cfg = '0;
        pending.insert(pending.size(), t);
        if (m != MODE_UNUSED) reqs++;
    endtask

    task automatic push_cfg(int value);
        t_item t;
        int v;
        t.kind = K_CFG;
        t.cfg = value;
        t.mode = gbf_pkg::MODE_LOAD;
        t.a = '0;
        t.b = '0;
        pending.insert(pending.size(), t);
        v = value & 32'h7f;
        gen_vc = v < 1 ? 1 : (v > NV ? NV : v);
    endtask

    task automatic push_drain();
        t_item t;
        t.kind = K_DRAIN;
        t.mode = gbf_pkg::MODE_LOAD;
        t.a = '0;
        t.b = '0;
        t.cfg = '0;
        pending.insert(pending.size(), t);
    endtask

    initial begin
        int span, n, pick;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = gbf_pkg::MODE_LOAD;
        i_end_a = '0;
        i_end_b = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = REG_VERTEX_COUNT;
        pwdata = '0;
        vc_now = NV;
        gen_vc = NV;
        edge_cnt = 0;
        drop_seen = 0;
        mismatches = 0;
        quiet = 0;
        stall = 0;
        gap_left = 0;
        apb_phase = 0;
        acc = 0;
        burst = 0;
        reqs = 0;
        rst_done = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        rst_done = 1;

        // directed: empty graph, triangle, self-loop, parallel pair, bad loads
        push_req(gbf_pkg::MODE_RUN);
        push_req(gbf_pkg::MODE_LOAD, 1, 2);
        push_req(gbf_pkg::MODE_LOAD, 2, 3);
        push_req(gbf_pkg::MODE_LOAD, 3, 1);
        push_req(gbf_pkg::MODE_LOAD, 3, 4);
        push_req(gbf_pkg::MODE_LOAD, 4, 4);
        push_req(gbf_pkg::MODE_LOAD, 4, 5);
        push_req(gbf_pkg::MODE_LOAD, 5, 4);
        push_req(gbf_pkg::MODE_LOAD, 64, 1);
        push_req(gbf_pkg::MODE_RUN);
        push_req(gbf_pkg::MODE_LOAD, 0, 2);
        push_req(gbf_pkg::MODE_LOAD, 2, 65);
        push_req(gbf_pkg::MODE_LOAD, 127, 127);
        push_req(MODE_UNUSED, 5, 6);
        push_req(gbf_pkg::MODE_RUN);
        push_cfg(3);            // shrunk: edges past vertex 3 drop out
        push_req(gbf_pkg::MODE_RUN);
        push_cfg(0);
        push_req(gbf_pkg::MODE_LOAD, 1, 1);
        push_req(gbf_pkg::MODE_LOAD, 1, 2);
        push_req(gbf_pkg::MODE_RUN);
        push_cfg(127);
        push_req(gbf_pkg::MODE_CLEAR);
        push_req(gbf_pkg::MODE_RUN);
        push_cfg(2);
        push_req(gbf_pkg::MODE_LOAD, 1, 2);
        push_req(gbf_pkg::MODE_RUN);

        // long path over all vertices: 63 bridges
        push_cfg(64);
        push_req(gbf_pkg::MODE_CLEAR);
        for (int i = 0; i < 63; i++) push_req(gbf_pkg::MODE_LOAD, i + 1, i + 2);
        push_req(gbf_pkg::MODE_RUN);
        push_drain();

        while (reqs < 220) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                push_drain();
                case ($urandom_range(0, 3))
                    0: push_cfg(1);
                    1: push_cfg(64);
                    default: push_cfg($urandom_range(0, 127));
                endcase
            end
            if (pick < 85) begin
                if ($urandom_range(0, 3) != 0) push_req(gbf_pkg::MODE_CLEAR);
                span = $urandom_range(2, 16);
                if (span > gen_vc) span = gen_vc;
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 15) == 0)
                        push_req(gbf_pkg::MODE_LOAD, $urandom_range(0, 127),
                                 $urandom_range(0, 127));
                    else
                        push_req(gbf_pkg::MODE_LOAD, $urandom_range(1, span),
                                 $urandom_range(1, span));
                end
                push_req(gbf_pkg::MODE_RUN);
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_req(gbf_pkg::MODE_W'($urandom_range(0, 3)), $urandom_range(0, 127),
                             $urandom_range(0, 127));
                push_req(gbf_pkg::MODE_RUN);
            end
        end

        wait (pending.size() == 0 && !start && apb_phase == 0);
        wait (bridges_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && bridges_due.size() == 0)
            $display("graph_bridge_finder_unit: match");
        else
            $display("graph_bridge_finder_unit: mismatch");
        $finish;
    end

endmodule
